/* sv/idwm_pkg.sv */
// Shared types and constants for the I2C display write master.
// Used by idwm_step and i2c_display_write_master; no dependencies.
package idwm_pkg;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_START_A   = 4'd1,
        PH_START_B   = 4'd2,
        PH_START_C   = 4'd3,
        PH_BIT_LOW   = 4'd4,
        PH_BIT_HIGH  = 4'd5,
        PH_ACK_REL   = 4'd6,
        PH_ACK_HIGH  = 4'd7,
        PH_ACK_POLL  = 4'd8,
        PH_ACK_LOW   = 4'd9,
        PH_STOP_SET  = 4'd10,
        PH_STOP_HIGH = 4'd11
    } phase_t;

    // APB register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_HALF_PERIOD = 2'd0;
    localparam logic [1:0] REG_ACK_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_DEV_ADDR    = 2'd2;

    localparam logic [15:0] HALF_PERIOD_RST = 16'd120;
    localparam logic [7:0]  ACK_TIMEOUT_RST = 8'd255;
    localparam logic [7:0]  DEV_ADDR_RST    = 8'h78;

    localparam logic [7:0] CTRL_DATA = 8'h40;
    localparam logic [7:0] CTRL_CMD  = 8'h00;

    localparam logic [1:0] SLOT_ADDR    = 2'd0;
    localparam logic [1:0] SLOT_CTRL    = 2'd1;
    localparam logic [1:0] SLOT_PAYLOAD = 2'd2;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef struct packed {
        phase_t      phase;
        logic [1:0]  byte_slot;
        logic [3:0]  bit_count;
        logic [15:0] delay_counter;
        logic [7:0]  ack_counter;
        logic [7:0]  shift_byte;
        logic [7:0]  held_payload;
        logic        held_kind;
        logic        nack_flag;
    } state_t;

    localparam state_t STATE_RST = '{
        phase:         PH_IDLE,
        byte_slot:     2'd0,
        bit_count:     4'd0,
        delay_counter: 16'd0,
        ack_counter:   8'd0,
        shift_byte:    8'd0,
        held_payload:  8'd0,
        held_kind:     1'b0,
        nack_flag:     1'b0
    };

    typedef struct packed {
        logic [15:0] half_period_ticks;
        logic [7:0]  ack_timeout_ticks;
        logic [7:0]  device_address_byte;
    } cfg_t;

    typedef struct packed {
        logic scl_level;
        logic sda_level;
        logic busy_res;
        logic frame_done;
        logic nack_seen;
    } res_t;

endpackage

/* sv/idwm_step.sv */
// One bus tick of the I2C write sequencer: next state and line levels.
// Depends on idwm_pkg.
module idwm_step (
    input  idwm_pkg::state_t cur,
    input  idwm_pkg::cfg_t   cfg,
    input  logic             start_request,
    input  logic [7:0]       payload_byte,
    input  logic             is_data,
    input  logic             sda_in,
    output idwm_pkg::state_t nxt,
    output idwm_pkg::res_t   res
);
    import idwm_pkg::*;

    logic [15:0] hp;
    logic [7:0]  to;
    logic [16:0] delay_inc;
    logic        delay_run;
    logic [7:0]  ack_inc;
    logic [3:0]  bit_inc;
    logic [1:0]  slot_inc;
    logic [7:0]  slot_byte;
    logic        done;
    logic        bit_out;

    // byte loaded for the slot that follows the current one
    function automatic logic [7:0] slot_value(input logic [1:0] slot, input state_t s,
                                              input logic [7:0] dev);
        logic [7:0] v;
        case (slot)
            SLOT_ADDR: v = dev;
            SLOT_CTRL: v = s.held_kind ? CTRL_DATA : CTRL_CMD;
            default:   v = s.held_payload;
        endcase
        return v;
    endfunction

    assign hp        = (cfg.half_period_ticks == 16'd0) ? 16'd1 : cfg.half_period_ticks;
    assign to        = (cfg.ack_timeout_ticks == 8'd0) ? 8'd1 : cfg.ack_timeout_ticks;
    assign delay_inc = {1'b0, cur.delay_counter} + 17'd1;
    assign delay_run = delay_inc < {1'b0, hp};
    assign ack_inc   = cur.ack_counter + 8'd1;
    assign bit_inc   = cur.bit_count + 4'd1;
    assign slot_inc  = cur.byte_slot + 2'd1;
    assign slot_byte = slot_value(slot_inc, cur, cfg.device_address_byte);

    always_comb
    begin
        nxt  = cur;
        done = 1'b0;
        if (cur.phase == PH_IDLE)
        begin
            if (start_request)
            begin
                nxt.held_payload  = payload_byte;
                nxt.held_kind     = is_data;
                nxt.nack_flag     = 1'b0;
                nxt.byte_slot     = SLOT_ADDR;
                nxt.bit_count     = 4'd0;
                nxt.phase         = PH_START_A;
                nxt.delay_counter = 16'd0;
            end
        end
        else if (cur.phase == PH_ACK_POLL)
        begin
            // poll ignores the half period; sda low acks at once
            if (!sda_in)
            begin
                nxt.phase         = PH_ACK_LOW;
                nxt.delay_counter = 16'd0;
            end
            else
            begin
                nxt.ack_counter = ack_inc;
                if (ack_inc >= to)
                begin
                    nxt.nack_flag     = 1'b1;
                    nxt.phase         = PH_ACK_LOW;
                    nxt.delay_counter = 16'd0;
                end
            end
        end
        else if (delay_run)
        begin
            nxt.delay_counter = delay_inc[15:0];
        end
        else
        begin
            nxt.delay_counter = 16'd0;
            case (cur.phase)
                PH_START_A: nxt.phase = PH_START_B;
                PH_START_B: nxt.phase = PH_START_C;
                PH_START_C:
                begin
                    nxt.byte_slot  = SLOT_ADDR;
                    nxt.shift_byte = cfg.device_address_byte;
                    nxt.bit_count  = 4'd0;
                    nxt.phase      = PH_BIT_LOW;
                end
                PH_BIT_LOW: nxt.phase = PH_BIT_HIGH;
                PH_BIT_HIGH:
                begin
                    nxt.shift_byte = {cur.shift_byte[6:0], 1'b0};
                    nxt.bit_count  = bit_inc;
                    nxt.phase      = (bit_inc >= BITS_PER_BYTE) ? PH_ACK_REL : PH_BIT_LOW;
                end
                PH_ACK_REL: nxt.phase = PH_ACK_HIGH;
                PH_ACK_HIGH:
                begin
                    nxt.ack_counter = 8'd0;
                    nxt.phase       = PH_ACK_POLL;
                end
                PH_ACK_LOW:
                begin
                    if (cur.nack_flag || cur.byte_slot >= SLOT_PAYLOAD)
                        nxt.phase = PH_STOP_SET;
                    else
                    begin
                        nxt.byte_slot  = slot_inc;
                        nxt.shift_byte = slot_byte;
                        nxt.bit_count  = 4'd0;
                        nxt.phase      = PH_BIT_LOW;
                    end
                end
                PH_STOP_SET: nxt.phase = PH_STOP_HIGH;
                PH_STOP_HIGH:
                begin
                    done      = 1'b1;
                    nxt.phase = PH_IDLE;
                end
                default: nxt.phase = PH_IDLE;
            endcase
        end
    end

    // line levels follow the phase just entered
    assign bit_out = nxt.shift_byte[7];

    always_comb
    begin
        case (nxt.phase)
            PH_START_B:   begin res.scl_level = 1'b1; res.sda_level = 1'b0;    end
            PH_START_C:   begin res.scl_level = 1'b0; res.sda_level = 1'b0;    end
            PH_BIT_LOW:   begin res.scl_level = 1'b0; res.sda_level = bit_out; end
            PH_BIT_HIGH:  begin res.scl_level = 1'b1; res.sda_level = bit_out; end
            PH_ACK_REL:   begin res.scl_level = 1'b0; res.sda_level = 1'b1;    end
            PH_ACK_LOW:   begin res.scl_level = 1'b0; res.sda_level = 1'b1;    end
            PH_STOP_SET:  begin res.scl_level = 1'b0; res.sda_level = 1'b0;    end
            PH_STOP_HIGH: begin res.scl_level = 1'b1; res.sda_level = 1'b0;    end
            default:      begin res.scl_level = 1'b1; res.sda_level = 1'b1;    end
        endcase
        res.busy_res   = (nxt.phase != PH_IDLE);
        res.frame_done = done;
        res.nack_seen  = done & cur.nack_flag;
    end

endmodule

/* sv/i2c_display_write_master.sv */
// I2C display write master: one bus tick per input transfer, one result per tick.
// An accepted transfer is held in the input registers and processed once the result
// register is free or draining; its result stays valid until taken. Throughput: one transfer
// per cycle while m_tready holds up, set by the state update between the input and result registers.
// Reset (rst_n low, async): sequencer idle, no result valid, config at defaults; result data is not reset.
// Depends on idwm_pkg and idwm_step.
module i2c_display_write_master (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [0] start_request, [8:1] payload_byte, [9] sda_in
    input  logic [0:0]  s_tuser,   // [0] is_data
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [0] scl_level, [1] sda_level, [2] busy_res, [3] nack_seen
    output logic        m_tlast,   // frame_done
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import idwm_pkg::*;

    cfg_t        cfg_reg;
    state_t      st_reg;
    state_t      st_next;
    res_t        res_next;
    res_t        res_reg;
    logic        in_valid_reg;
    logic        in_start_reg;
    logic [7:0]  in_payload_reg;
    logic        in_kind_reg;
    logic        in_sda_reg;
    logic        out_valid_reg;
    logic        fire;
    logic        wr_en;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.half_period_ticks   <= HALF_PERIOD_RST;
            cfg_reg.ack_timeout_ticks   <= ACK_TIMEOUT_RST;
            cfg_reg.device_address_byte <= DEV_ADDR_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_HALF_PERIOD: cfg_reg.half_period_ticks   <= pwdata[15:0];
                REG_ACK_TIMEOUT: cfg_reg.ack_timeout_ticks   <= pwdata[7:0];
                REG_DEV_ADDR:    cfg_reg.device_address_byte <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_HALF_PERIOD: prdata = {16'd0, cfg_reg.half_period_ticks};
            REG_ACK_TIMEOUT: prdata = {24'd0, cfg_reg.ack_timeout_ticks};
            REG_DEV_ADDR:    prdata = {24'd0, cfg_reg.device_address_byte};
            default:         prdata = 32'd0;
        endcase
    end

    // process the held transfer when the result slot is free or draining
    assign fire     = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~in_valid_reg | fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready & s_tvalid)
        begin
            in_start_reg   <= s_tdata[0];
            in_payload_reg <= s_tdata[8:1];
            in_sda_reg     <= s_tdata[9];
            in_kind_reg    <= s_tuser[0];
        end
    end

    idwm_step u_step (
        .cur           (st_reg),
        .cfg           (cfg_reg),
        .start_request (in_start_reg),
        .payload_byte  (in_payload_reg),
        .is_data       (in_kind_reg),
        .sda_in        (in_sda_reg),
        .nxt           (st_next),
        .res           (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= STATE_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
                st_reg <= st_next;
            if (fire)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            res_reg <= res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, res_reg.nack_seen, res_reg.busy_res,
                       res_reg.sda_level, res_reg.scl_level};
    assign m_tlast  = res_reg.frame_done;

endmodule
